### hw/rtl/qacd_pkg.sv
// ----------------------------------------------------------------------------
// qacd_pkg
// Widths, defaults and controller states shared by the duration quantizer
// with distinct-value counter and its channel interfaces.
// ----------------------------------------------------------------------------
package qacd_pkg;

  localparam int DUR_W            = 32;
  localparam int RES_W            = 32;
  localparam int VAL_W            = 33;
  localparam int CNT_OUT_W        = 7;
  localparam int MAX_DISTINCT_DEF = 64;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_ROUND,
    ST_ADJ,
    ST_SEARCH,
    ST_UPDATE,
    ST_FINISH
  } qacd_state_t;

endpackage

### hw/rtl/qacd_if.sv
// ----------------------------------------------------------------------------
// qacd_in_if / qacd_out_if
// Valid/ready channels of the duration quantizer: durations in, rounded
// values with distinct counts out.
// ----------------------------------------------------------------------------
interface qacd_in_if;
  import qacd_pkg::*;

  logic             valid;
  logic             ready;
  logic [DUR_W-1:0] duration;
  logic             last_item;

  modport source (output valid, output duration, output last_item, input ready);
  modport sink   (input valid, input duration, input last_item, output ready);
endinterface

interface qacd_out_if;
  import qacd_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [VAL_W-1:0]     rounded_value;
  logic [CNT_OUT_W-1:0] distinct_count;
  logic                 overflow;
  logic                 set_done;

  modport source (output valid, output rounded_value, output distinct_count,
                  output overflow, output set_done, input ready);
  modport sink   (input valid, input rounded_value, input distinct_count,
                  input overflow, input set_done, output ready);
endinterface

### hw/rtl/quantize_and_count_distinct.sv
// ----------------------------------------------------------------------------
// quantize_and_count_distinct
// Rounds durations to the nearest multiple of a resolution (ties up, never
// zero) and counts the distinct rounded values within each set.
//
//   channel   dir   payload                                          handshake
//   in_ch     in    duration[31:0], last_item                        valid/ready
//   out_ch    out   rounded_value[32:0], distinct_count[6:0],        valid/ready
//                   overflow, set_done
//   cfg       in    cfg_wdata[31:0] (resolution)                     cfg_we
//
// One transaction at a time: a bit-serial remainder over all 32 duration bits
// (ST_DIV), rounding in ST_ROUND and ST_ADJ, a scan of the value memory at one
// entry per cycle (up to the stored count), an update state (ST_UPDATE) and the
// output load (ST_FINISH). The memory scan, set by the stored count, sets the
// spread. A full output register stalls the output load only; a new transaction
// is taken in ST_IDLE once the previous one is loaded.
// Reset (rst_n, synchronous) clears the count, overflow flag and resolution
// (to 1); the value memory needs no clearing.
// ----------------------------------------------------------------------------
module quantize_and_count_distinct #(
  parameter int MAX_DISTINCT = qacd_pkg::MAX_DISTINCT_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [qacd_pkg::RES_W-1:0] cfg_wdata,
  qacd_in_if.sink                   in_ch,
  qacd_out_if.source                out_ch
);
  import qacd_pkg::*;

  localparam int AW   = $clog2(MAX_DISTINCT);
  localparam int CW   = $clog2(MAX_DISTINCT + 1);
  localparam int BC_W = $clog2(DUR_W);

  qacd_state_t state_r, state_nxt;

  logic [RES_W-1:0] res_r;
  logic [DUR_W-1:0] dur_r;
  logic [DUR_W-1:0] dvd_r;
  logic [RES_W-1:0] step_r;
  logic [RES_W-1:0] rem_r;
  logic [BC_W-1:0]  bit_cnt_r;
  logic             last_r;
  logic             up_r;
  logic [VAL_W-1:0] val_r;
  logic [CW-1:0]    cnt_r;
  logic             ovf_r;
  logic [CW-1:0]    idx_r;
  logic             rd_vld_r;
  logic [VAL_W-1:0] rd_data_r;
  logic             found_r;

  logic                 out_valid_r;
  logic [VAL_W-1:0]     out_val_r;
  logic [CNT_OUT_W-1:0] out_cnt_r;
  logic                 out_ovf_r;
  logic                 out_done_r;

  logic [VAL_W-1:0] mem [MAX_DISTINCT];

  logic             in_ready;
  logic             in_acc;
  logic             rd_en;
  logic             mem_we;
  logic             out_load;
  logic             hit;
  logic             scan_done;
  logic             div_last;
  logic [VAL_W-1:0] trial;
  logic             trial_ge;
  logic             out_free;

  assign in_acc    = in_ch.valid && in_ready;
  assign hit       = rd_vld_r && (rd_data_r == val_r);
  assign scan_done = (idx_r == cnt_r) && !rd_vld_r;
  assign div_last  = (bit_cnt_r == BC_W'(DUR_W - 1));
  assign trial     = {rem_r, dvd_r[DUR_W-1]};
  assign trial_ge  = (trial >= {1'b0, step_r});
  assign out_free  = !out_valid_r || out_ch.ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_ch.valid) state_nxt = ST_DIV;
      ST_DIV:    if (div_last) state_nxt = ST_ROUND;
      ST_ROUND:  state_nxt = ST_ADJ;
      ST_ADJ:    state_nxt = ST_SEARCH;
      ST_SEARCH: if (hit || scan_done) state_nxt = ST_UPDATE;
      ST_UPDATE: state_nxt = ST_FINISH;
      ST_FINISH: if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    rd_en    = 1'b0;
    mem_we   = 1'b0;
    out_load = 1'b0;
    unique case (state_r)
      ST_IDLE:   in_ready = 1'b1;
      ST_SEARCH: rd_en = !hit && (idx_r != cnt_r);
      ST_UPDATE: mem_we = !found_r && (cnt_r < CW'(MAX_DISTINCT));
      ST_FINISH: out_load = out_free;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      res_r       <= RES_W'(1);
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= rd_en;
      if (cfg_we) begin
        res_r <= cfg_wdata;
      end
      if (mem_we) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (state_r == ST_UPDATE && !found_r) begin
        ovf_r <= 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
        if (last_r) begin
          cnt_r <= '0;
          ovf_r <= 1'b0;
        end
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      dur_r     <= in_ch.duration;
      dvd_r     <= in_ch.duration;
      last_r    <= in_ch.last_item;
      step_r    <= (res_r == '0) ? RES_W'(1) : res_r;
      rem_r     <= '0;
      bit_cnt_r <= '0;
    end
    if (state_r == ST_DIV) begin
      rem_r     <= trial_ge ? RES_W'(trial - {1'b0, step_r}) : RES_W'(trial);
      dvd_r     <= {dvd_r[DUR_W-2:0], 1'b0};
      bit_cnt_r <= bit_cnt_r + BC_W'(1);
    end
    if (state_r == ST_ROUND) begin
      val_r <= {1'b0, dur_r} - {1'b0, rem_r};
      up_r  <= ({rem_r, 1'b0} >= {1'b0, step_r});
    end
    if (state_r == ST_ADJ) begin
      idx_r   <= '0;
      found_r <= 1'b0;
      if (up_r) begin
        val_r <= val_r + {1'b0, step_r};
      end else if (val_r == '0) begin
        val_r <= {1'b0, step_r};
      end
    end
    if (rd_en) begin
      idx_r <= idx_r + CW'(1);
    end
    if (state_r == ST_SEARCH && hit) begin
      found_r <= 1'b1;
    end
    if (out_load) begin
      out_val_r  <= val_r;
      out_cnt_r  <= CNT_OUT_W'(cnt_r);
      out_ovf_r  <= ovf_r;
      out_done_r <= last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[cnt_r[AW-1:0]] <= val_r;
    end
    if (rd_en) begin
      rd_data_r <= mem[idx_r[AW-1:0]];
    end
  end

  assign in_ch.ready           = in_ready;
  assign out_ch.valid          = out_valid_r;
  assign out_ch.rounded_value  = out_val_r;
  assign out_ch.distinct_count = out_cnt_r;
  assign out_ch.overflow       = out_ovf_r;
  assign out_ch.set_done       = out_done_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_DISTINCT))
    else $error("distinct count above capacity");

  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |-> (cnt_r == CW'(MAX_DISTINCT)))
    else $error("overflow flagged with free entries");

  a_set_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && last_r) |=> (cnt_r == '0) && !ovf_r)
    else $error("set state not cleared after last transaction");

  a_rd_range: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> (idx_r < cnt_r))
    else $error("read beyond stored entries");

endmodule

### bench/qacd_checker.sv
// ----------------------------------------------------------------------------
// qacd_checker
// Watches both channels of the duration quantizer. Each accepted input
// transaction is rounded and counted by a local copy of the set logic, and
// each accepted result transaction is compared, field by field, with the
// oldest expected result.
// ----------------------------------------------------------------------------
module qacd_checker #(
  parameter int MAX_DISTINCT = qacd_pkg::MAX_DISTINCT_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [qacd_pkg::RES_W-1:0] cfg_wdata,
  qacd_in_if                         in_ch,
  qacd_out_if                        out_ch,
  output int                         fail_count,
  output int                         pending
);
  import qacd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [VAL_W-1:0]     rounded_value;
    logic [CNT_OUT_W-1:0] distinct_count;
    logic                 overflow;
    logic                 set_done;
  } qacd_result_t;

  qacd_result_t     expected_results[$];
  logic [RES_W-1:0] step_reg;
  logic [VAL_W-1:0] seen_values[MAX_DISTINCT];
  int               seen_count;
  logic             overflow_seen;
  int               fails;

  function automatic logic [VAL_W-1:0] round_to_step(logic [DUR_W-1:0] dur,
                                                     logic [RES_W-1:0] res);
    logic [63:0] step;
    logic [63:0] quot;
    logic [63:0] rem;
    logic [63:0] val;
    step = (res == '0) ? 64'd1 : {32'd0, res};
    quot = {32'd0, dur} / step;
    rem  = {32'd0, dur} - quot * step;
    if (rem * 2 >= step) quot = quot + 1;
    val = quot * step;
    if (val == 0) val = step;
    return val[VAL_W-1:0];
  endfunction

  function automatic void count_duration(logic [DUR_W-1:0] dur, logic last);
    logic [VAL_W-1:0] val;
    bit               found;
    qacd_result_t     res;
    val   = round_to_step(dur, step_reg);
    found = 1'b0;
    for (int i = 0; i < seen_count; i++) begin
      if (seen_values[i] == val) found = 1'b1;
    end
    if (!found) begin
      if (seen_count < MAX_DISTINCT) begin
        seen_values[seen_count] = val;
        seen_count++;
      end else begin
        overflow_seen = 1'b1;
      end
    end
    res.rounded_value  = val;
    res.distinct_count = CNT_OUT_W'(seen_count);
    res.overflow       = overflow_seen;
    res.set_done       = last;
    expected_results.push_back(res);
    if (last) begin
      seen_count    = 0;
      overflow_seen = 1'b0;
    end
  endfunction

  function automatic bit field_ok(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (act_v === exp_v) return 1'b1;
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
    return 1'b0;
  endfunction

  always @(posedge clk) begin
    qacd_result_t want;
    bit           ok;
    if (!rst_n) begin
      step_reg      = 32'd1;
      seen_count    = 0;
      overflow_seen = 1'b0;
      fails         = 0;
      expected_results.delete();
    end else begin
      if (cfg_we) step_reg = cfg_wdata;
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual value %0h count %0d",
                   $time, out_ch.rounded_value, out_ch.distinct_count);
          fails++;
        end else begin
          want = expected_results.pop_front();
          ok = field_ok("rounded_value", 64'(want.rounded_value),
                        64'(out_ch.rounded_value));
          ok = field_ok("distinct_count", 64'(want.distinct_count),
                        64'(out_ch.distinct_count)) && ok;
          ok = field_ok("overflow", 64'(want.overflow), 64'(out_ch.overflow)) && ok;
          ok = field_ok("set_done", 64'(want.set_done), 64'(out_ch.set_done)) && ok;
          if (!ok) fails++;
        end
      end
      if (in_ch.valid && in_ch.ready) count_duration(in_ch.duration, in_ch.last_item);
    end
    fail_count <= fails;
    pending    <= expected_results.size();
  end

endmodule

### bench/quantize_and_count_distinct_test.sv
// ----------------------------------------------------------------------------
// quantize_and_count_distinct_test
// Drives sets of durations into the quantizer under a series of resolutions,
// with random gaps on both channels and one long result stall. A checker
// beside the block predicts every result; the verdict comes from its failure
// and pending counts and from a watchdog on stalled handshakes.
// ----------------------------------------------------------------------------
module quantize_and_count_distinct_test;
  import qacd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_CYCLES = 600;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [RES_W-1:0] cfg_wdata;
  int               fail_count;
  int               pending;
  int               items_sent;
  int               stall_cycles;
  bit               send_burst;
  logic [RES_W-1:0] cur_res;
  logic [DUR_W-1:0] value_pool[8];

  qacd_in_if  in_ch ();
  qacd_out_if out_ch ();

  quantize_and_count_distinct dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  qacd_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic refill_pool();
    for (int j = 0; j < 8; j++) begin
      value_pool[j] = (j < 4) ? $urandom : DUR_W'(j * cur_res + cur_res / 2);
    end
  endtask

  function automatic logic [DUR_W-1:0] pick_duration(logic [RES_W-1:0] res, bit wide);
    logic [63:0] step;
    logic [63:0] v;
    step = (res == '0) ? 64'd1 : {32'd0, res};
    if (wide && $urandom_range(0, 9) != 0) return $urandom;
    case ($urandom_range(0, 5))
      0: v = 64'($urandom);
      1: v = 64'(value_pool[$urandom_range(0, 7)]);
      2: v = $urandom_range(0, 40) * step + step / 2 + $urandom_range(0, 2) - 1;
      3: v = {32'd0, $urandom} % (step + 1);
      4: begin
        case ($urandom_range(0, 2))
          0: v = 64'd0;
          1: v = 64'hFFFF_FFFF;
          default: v = 64'h8000_0000;
        endcase
      end
      default: v = $urandom_range(0, 40) * step;
    endcase
    return v[DUR_W-1:0];
  endfunction

  task automatic send_item(input logic [DUR_W-1:0] dur, input logic last);
    int gap;
    if (items_sent % 50 == 0) send_burst = ($urandom_range(0, 3) == 0);
    gap = send_burst ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.duration  <= dur;
    in_ch.last_item <= last;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    items_sent++;
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic set_resolution(input logic [RES_W-1:0] res);
    wait_drained();
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= res;
    @(posedge clk);
    cfg_we  <= 1'b0;
    cur_res = res;
    refill_pool();
  endtask

  task automatic run_random_sets(input int n_items);
    int  sent;
    int  len;
    int  pick;
    bit  wide;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(0, 19);
      wide = (pick < 3);
      if (wide) len = $urandom_range(60, 90);
      else if (pick == 3) len = 1;
      else len = $urandom_range(2, 16);
      for (int i = 0; i < len; i++) begin
        send_item(pick_duration(cur_res, wide), i == len - 1);
      end
      sent += len;
    end
  endtask

  initial begin : result_sink
    int gap;
    int results;
    bit burst;
    out_ch.ready <= 1'b0;
    results = 0;
    burst   = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (results % 50 == 0) burst = ($urandom_range(0, 3) == 0);
      gap = burst ? 0 : $urandom_range(0, 18);
      if (results == 150) gap = HOLD_CYCLES;
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
      results++;
    end
  end

  initial begin : watchdog
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        stall_cycles = 0;
      else
        stall_cycles++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : stimulus
    in_ch.valid     <= 1'b0;
    in_ch.duration  <= '0;
    in_ch.last_item <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_wdata       <= '0;
    rst_n           <= 1'b0;
    cur_res    = 32'd1;
    items_sent = 0;
    send_burst = 1'b0;
    refill_pool();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    send_item(32'd0, 1'b0);
    send_item(32'd1, 1'b0);
    send_item(32'hFFFF_FFFF, 1'b0);
    send_item(32'd1, 1'b0);
    send_item(32'hFFFF_FFFE, 1'b1);
    run_random_sets(280);

    set_resolution(32'hFFFF_FFFF);
    send_item(32'h7FFF_FFFF, 1'b0);
    send_item(32'h8000_0000, 1'b0);
    send_item(32'hFFFF_FFFF, 1'b0);
    send_item(32'd0, 1'b0);
    send_item(32'hFFFF_FFFF, 1'b1);
    run_random_sets(280);

    set_resolution(32'd10);
    send_item(32'd15, 1'b0);
    send_item(32'd14, 1'b0);
    send_item(32'd4, 1'b0);
    send_item(32'd5, 1'b0);
    send_item(32'd25, 1'b0);
    send_item(32'd0, 1'b1);
    run_random_sets(280);

    set_resolution(32'd0);
    send_item(32'd0, 1'b0);
    send_item(32'd5, 1'b0);
    send_item(32'hFFFF_FFFF, 1'b1);
    run_random_sets(280);

    set_resolution(32'd3);
    run_random_sets(280);
    set_resolution($urandom);
    run_random_sets(280);
    set_resolution(32'd1000);
    run_random_sets(280);
    set_resolution(32'd1);
    run_random_sets(100);

    wait_drained();
    repeat (150) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
